// ===== sv/ppp_pkg.sv =====
package ppp_pkg;

  localparam int NUM_REGS = 6;
  localparam int REG_W = 64;
  localparam int IDX_W = 3;
  localparam int W32 = 32;
  localparam int FAR_SCALE = 100000;

  localparam logic [IDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_A = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROWW_A = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROWW_B = 3'd5;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] t;
  } row_coef_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== sv/ppp_dot.sv =====
module ppp_dot import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  row_coef_t          coef,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic signed [31:0] dot
);

  logic signed [63:0] p0, p1, p2;
  logic signed [31:0] tr;
  logic signed [65:0] acc;

  always_ff @(posedge clk) begin
    p0 <= coef.c0 * px;
    p1 <= coef.c1 * py;
    p2 <= coef.c2 * pz;
    tr <= coef.t;
  end

  always_comb begin
    acc = 66'(p0 >>> FRAC_BITS) + 66'(p1 >>> FRAC_BITS) + 66'(p2 >>> FRAC_BITS)
        + 66'(tr);
  end

  always_ff @(posedge clk) begin
    dot <= sat32(acc);
  end

endmodule

// ===== sv/ppp_div.sv =====
module ppp_div import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  input  logic               far,
  output logic signed [31:0] quo
);

  localparam int NW = 32 + FRAC_BITS + 1;
  localparam int STAGES = NW;

  logic [NW-1:0]         rem   [STAGES+1];
  logic [NW-1:0]         qbits [STAGES+1];
  logic [31:0]           dv    [STAGES+1];
  logic                  neg   [STAGES+1];
  logic                  fr    [STAGES+1];
  logic signed [31:0]    fv    [STAGES+1];
  logic [32:0]           mag;
  logic signed [65:0]    farprod;
  logic [NW-1:0]         qf;

  assign mag = num[31] ? 33'(-34'(num)) : 33'(num);
  assign farprod = 66'(num) * 66'(FAR_SCALE);

  always_comb begin
    rem[0]   = '0;
    qbits[0] = NW'(mag) << FRAC_BITS;
    dv[0]    = den;
    neg[0]   = num[31];
    fr[0]    = far;
    fv[0]    = sat32(farprod);
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_step
    logic [NW:0] r2;
    logic [NW:0] d2;
    assign r2 = {rem[s], qbits[s][NW-1]};
    assign d2 = (NW+1)'(dv[s]);
    always_ff @(posedge clk) begin
      if (r2 >= d2) begin
        rem[s+1] <= NW'(r2 - d2);
        qbits[s+1] <= {qbits[s][NW-2:0], 1'b1};
      end else begin
        rem[s+1] <= NW'(r2);
        qbits[s+1] <= {qbits[s][NW-2:0], 1'b0};
      end
      dv[s+1]  <= dv[s];
      neg[s+1] <= neg[s];
      fr[s+1]  <= fr[s];
      fv[s+1]  <= fv[s];
    end
  end

  always_comb begin
    qf = qbits[STAGES];
    if (fr[STAGES]) begin
      quo = fv[STAGES];
    end else if (neg[STAGES]) begin
      quo = (qf >= NW'(33'h080000000)) ? 32'sh80000000 : -$signed(qf[31:0]);
    end else begin
      quo = (qf >= NW'(33'h080000000)) ? 32'sh7fffffff : $signed(qf[31:0]);
    end
  end

endmodule

// ===== sv/perspective_point_projection_top.sv =====
// Path from accepted start to done: registered products, saturated dot-product sum, w clamp register, divider stages.
// Throughput: one request per cycle; the restoring divider is fully unrolled, one bit a stage.
// busy stays low; the receiver cannot stall, so done pulses one cycle per request.
// Reset: synchronous, clears valid bits and loads the identity-like matrix defaults.
module perspective_point_projection_top import ppp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_idx,
  input  logic [REG_W-1:0]   cfg_data,
  output logic               done,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               behind
);

  localparam int DLAT = 32 + FRAC_BITS + 1;
  localparam int LAT = 3 + DLAT;
  localparam logic signed [31:0] THRESH = 32'(((1 << FRAC_BITS) + 999) / 1000);

  logic [REG_W-1:0] regs [NUM_REGS];
  logic [LAT-1:0]   vpipe;
  logic [DLAT-1:0]  bpipe;
  logic signed [31:0] xd, yd, wd, xr, yr, wr;
  logic             bh;
  row_coef_t        c0, c1, cw;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW0_A] <= 64'd65536;
      regs[REG_ROW0_B] <= '0;
      regs[REG_ROW1_A] <= 64'd281474976710656;
      regs[REG_ROW1_B] <= '0;
      regs[REG_ROWW_A] <= '0;
      regs[REG_ROWW_B] <= 64'd281474976710656;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW0_A: regs[REG_ROW0_A] <= cfg_data;
        REG_ROW0_B: regs[REG_ROW0_B] <= cfg_data;
        REG_ROW1_A: regs[REG_ROW1_A] <= cfg_data;
        REG_ROW1_B: regs[REG_ROW1_B] <= cfg_data;
        REG_ROWW_A: regs[REG_ROWW_A] <= cfg_data;
        REG_ROWW_B: regs[REG_ROWW_B] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign c0 = {regs[REG_ROW0_A][31:0], regs[REG_ROW0_A][63:32],
               regs[REG_ROW0_B][31:0], regs[REG_ROW0_B][63:32]};
  assign c1 = {regs[REG_ROW1_A][31:0], regs[REG_ROW1_A][63:32],
               regs[REG_ROW1_B][31:0], regs[REG_ROW1_B][63:32]};
  assign cw = {regs[REG_ROWW_A][31:0], regs[REG_ROWW_A][63:32],
               regs[REG_ROWW_B][31:0], regs[REG_ROWW_B][63:32]};

  ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .coef(c0), .px(pos_x), .py(pos_y),
    .pz(pos_z), .dot(xd));
  ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .coef(c1), .px(pos_x), .py(pos_y),
    .pz(pos_z), .dot(yd));
  ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dw (.clk, .coef(cw), .px(pos_x), .py(pos_y),
    .pz(pos_z), .dot(wd));

  always_ff @(posedge clk) begin
    xr <= xd;
    yr <= yd;
    wr <= (wd < THRESH) ? 32'sd1 : wd;
    bh <= wd < THRESH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    bpipe <= {bpipe[DLAT-2:0], bh};
  end

  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_qx (.clk, .num(xr), .den(wr),
    .far(bh), .quo(screen_x));
  ppp_div #(.FRAC_BITS(FRAC_BITS)) u_qy (.clk, .num(yr), .den(wr),
    .far(bh), .quo(screen_y));

  assign behind = bpipe[DLAT-1];
  assign done = vpipe[LAT-1];

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy asserted");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    vpipe[LAT-2] |=> done)
    else $error("done lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !vpipe[LAT-2] |=> !done)
    else $error("spurious done");

endmodule
